// ===== rtl/bsa_pkg.sv =====
package bsa_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int TOL_BITS       = 16;
    localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd66;

    localparam logic [1:0] CMD_POINT  = 2'd0;
    localparam logic [1:0] CMD_SPHERE = 2'd1;
    localparam logic [1:0] CMD_LOAD   = 2'd2;
    localparam logic [1:0] CMD_BOX    = 2'd3;

    localparam logic [2:0] REL_OUT        = 3'd0;
    localparam logic [2:0] REL_IN         = 3'd1;
    localparam logic [2:0] REL_ON         = 3'd2;
    localparam logic [2:0] REL_APART      = 3'd0;
    localparam logic [2:0] REL_TANGENT    = 3'd1;
    localparam logic [2:0] REL_OVERLAP    = 3'd2;
    localparam logic [2:0] REL_HELD_IN    = 3'd3;
    localparam logic [2:0] REL_INPUT_IN   = 3'd4;

    localparam logic [0:0] ADDR_TOLERANCE = 1'b0;

    typedef struct packed {
        logic [1:0]                   cmd;
        logic signed [COORD_BITS_DEF-1:0] in_x;
        logic signed [COORD_BITS_DEF-1:0] in_y;
        logic signed [COORD_BITS_DEF-1:0] in_z;
        logic [COORD_BITS_DEF-2:0]    in_radius;
        logic signed [COORD_BITS_DEF-1:0] box_x_high;
        logic signed [COORD_BITS_DEF-1:0] box_y_high;
        logic signed [COORD_BITS_DEF-1:0] box_z_high;
    } bsa_in_t;

    typedef struct packed {
        logic [2:0]                   relation;
        logic signed [COORD_BITS_DEF-1:0] out_x;
        logic signed [COORD_BITS_DEF-1:0] out_y;
        logic signed [COORD_BITS_DEF-1:0] out_z;
        logic [COORD_BITS_DEF-2:0]    out_radius;
        logic                         saturated;
    } bsa_out_t;

endpackage

// ===== rtl/bounding_sphere_accumulator.sv =====
// Channel | dir | payload         | handshake
// in      | in  | bsa_in_t        | in_valid / in_stall
// out     | out | bsa_out_t       | out_valid / out_stall
// cfg     | in  | tolerance (16b) | APB write at 0x0
//
// One item at a time. A distance is computed per axis as one difference step,
// 33 shift-add steps and one add; then 34 root steps (two radicand bits each).
// Per command: point or sphere kept/replaced, box (8 corners), sphere merge (per axis
// a difference, a shift-add multiply, a divide and an apply), load skips the distance.
// The next item is taken while a result waits; its own result holds the engine and
// the input stalls until the result register empties. Reset clears sphere, tolerance 66.
module bounding_sphere_accumulator
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  bsa_pkg::bsa_in_t      in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output bsa_pkg::bsa_out_t     out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import bsa_pkg::*;

    localparam int C  = COORD_BITS_DEF;
    localparam int M  = C + 1;          // axis difference magnitude
    localparam int SQ = 2 * M + 2;      // sum of three squares
    localparam int RT = M + 1;          // root width
    localparam int NW = 2 * RT;         // dividend width for move

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIFF  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_SQRT  = 4'd3;
    localparam logic [3:0] S_DECIDE= 4'd4;
    localparam logic [3:0] S_MDIFF = 4'd5;
    localparam logic [3:0] S_MMUL  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_MAPPLY= 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]  state_reg;
    logic [TOL_BITS-1:0] tol_reg;
    logic signed [C-1:0] cx_reg, cy_reg, cz_reg;
    logic [C-2:0] rad_reg;
    bsa_in_t     item_reg;
    logic [2:0]  corner_reg;
    logic [1:0]  axis_reg;
    logic [7:0]  cnt_reg;
    logic [M-1:0] mag_reg;       // multiplicand
    logic [M-1:0] mplr_reg;      // multiplier, shifted right
    logic [SQ-1:0] prod_reg;     // partial product accumulator
    logic [SQ-1:0] sum_reg;      // sum of squares
    logic [RT-1:0] root_reg;
    logic [SQ+1:0] rrem_reg;     // root remainder
    logic [SQ-1:0] rsrc_reg;     // shifting radicand
    logic [RT-1:0] best_reg;
    logic [RT-1:0] d_reg;
    logic [RT-1:0] t_reg;
    logic [NW-1:0] num_reg;
    logic [RT:0]   drem_reg;
    logic [NW-1:0] q_reg;
    logic          neg_reg;
    logic [2:0]    rel_reg;
    logic [RT:0]   newr_reg;
    logic          sat_reg;      // radius clamped for the item in the engine
    logic          ovalid_reg;
    bsa_out_t      out_reg;

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_TOLERANCE) ? {{(32-TOL_BITS){1'b0}}, tol_reg} : 32'd0;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ovalid_reg;
    assign out_data  = out_reg;

    // selected point coordinate for current corner/axis
    logic signed [C-1:0] pt_c, ctr_c;
    always_comb
    begin
        case (axis_reg)
            2'd0:
            begin
                pt_c  = (item_reg.cmd == CMD_BOX && corner_reg[0]) ? item_reg.box_x_high
                                                                   : item_reg.in_x;
                ctr_c = cx_reg;
            end
            2'd1:
            begin
                pt_c  = (item_reg.cmd == CMD_BOX && corner_reg[1]) ? item_reg.box_y_high
                                                                   : item_reg.in_y;
                ctr_c = cy_reg;
            end
            default:
            begin
                pt_c  = (item_reg.cmd == CMD_BOX && corner_reg[2]) ? item_reg.box_z_high
                                                                   : item_reg.in_z;
                ctr_c = cz_reg;
            end
        endcase
    end

    logic signed [M-1:0] diff_c;
    assign diff_c = {pt_c[C-1], pt_c} - {ctr_c[C-1], ctr_c};

    // root step: two radicand bits a cycle
    logic [SQ+1:0] rrem_sh, rtrial;
    assign rrem_sh = {rrem_reg[SQ-1:0], rsrc_reg[SQ-1 -: 2]};
    assign rtrial  = {{(SQ+2-RT-2){1'b0}}, root_reg, 2'b01};

    // division step: one dividend bit a cycle
    logic [RT:0] drem_sh;
    assign drem_sh = {drem_reg[RT-1:0], num_reg[NW-1]};

    // sphere tests, on the distance just computed
    logic [RT+1:0] s_a, s_b, s_d, s_ab;
    assign s_a  = {5'd0, rad_reg};
    assign s_b  = {5'd0, item_reg.in_radius};
    assign s_d  = {2'd0, root_reg};
    assign s_ab = s_a + s_b;
    logic [RT+1:0] s_sum;
    assign s_sum = s_d + s_ab;

    logic signed [C:0] moved;
    logic [C:0] qext;
    assign qext  = q_reg[C:0];
    assign moved = neg_reg ? ({ctr_c[C-1], ctr_c} - $signed(qext))
                           : ({ctr_c[C-1], ctr_c} + $signed(qext));

    logic signed [C-1:0] moved_c;
    assign moved_c = moved[C-1:0];

    logic [RT-1:0] pd;
    assign pd = (item_reg.cmd == CMD_BOX) ? best_reg : root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            tol_reg    <= TOL_RESET;
            cx_reg     <= '0;
            cy_reg     <= '0;
            cz_reg     <= '0;
            rad_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr[2] == ADDR_TOLERANCE)
                tol_reg <= pwdata[TOL_BITS-1:0];
            if (ovalid_reg && !out_stall && state_reg != S_DONE)
                ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg   <= in_data;
                        corner_reg <= '0;
                        axis_reg   <= '0;
                        best_reg   <= '0;
                        sum_reg    <= '0;
                        sat_reg    <= 1'b0;
                        state_reg  <= (in_data.cmd == CMD_LOAD) ? S_DECIDE : S_DIFF;
                    end
                end
                S_DIFF:
                begin
                    mag_reg   <= diff_c[M-1] ? -diff_c : diff_c;
                    mplr_reg  <= diff_c[M-1] ? -diff_c : diff_c;
                    prod_reg  <= '0;
                    cnt_reg   <= 8'(M);
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    // shift-add, one multiplier bit a cycle
                    if (cnt_reg == 8'd0)
                    begin
                        if (axis_reg == 2'd2)
                        begin
                            rsrc_reg  <= sum_reg + prod_reg;
                            rrem_reg  <= '0;
                            root_reg  <= '0;
                            cnt_reg   <= 8'(SQ / 2);
                            state_reg <= S_SQRT;
                        end
                        else
                        begin
                            sum_reg   <= sum_reg + prod_reg;
                            axis_reg  <= axis_reg + 2'd1;
                            state_reg <= S_DIFF;
                        end
                    end
                    else
                    begin
                        if (mplr_reg[0])
                            prod_reg <= prod_reg + ({{(SQ-M){1'b0}}, mag_reg}
                                                    << (8'(M) - cnt_reg));
                        mplr_reg <= mplr_reg >> 1;
                        cnt_reg  <= cnt_reg - 8'd1;
                    end
                end
                S_SQRT:
                begin
                    if (cnt_reg == 8'd0)
                    begin
                        axis_reg <= '0;
                        sum_reg  <= '0;
                        if (item_reg.cmd == CMD_BOX)
                        begin
                            if (root_reg > best_reg)
                                best_reg <= root_reg;
                            if (corner_reg == 3'd7)
                                state_reg <= S_DECIDE;
                            else
                            begin
                                corner_reg <= corner_reg + 3'd1;
                                state_reg  <= S_DIFF;
                            end
                        end
                        else
                            state_reg <= S_DECIDE;
                    end
                    else
                    begin
                        rsrc_reg <= rsrc_reg << 2;
                        if (rrem_sh >= rtrial)
                        begin
                            rrem_reg <= rrem_sh - rtrial;
                            root_reg <= {root_reg[RT-2:0], 1'b1};
                        end
                        else
                        begin
                            rrem_reg <= rrem_sh;
                            root_reg <= {root_reg[RT-2:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg - 8'd1;
                    end
                end
                S_DECIDE:
                begin
                    if (item_reg.cmd == CMD_LOAD)
                    begin
                        cx_reg    <= item_reg.in_x;
                        cy_reg    <= item_reg.in_y;
                        cz_reg    <= item_reg.in_z;
                        rad_reg   <= item_reg.in_radius;
                        rel_reg   <= REL_OUT;
                        state_reg <= S_DONE;
                    end
                    else if (item_reg.cmd != CMD_SPHERE)
                    begin
                        state_reg <= S_DONE;
                        if (pd < {3'd0, rad_reg})
                            rel_reg <= REL_IN;
                        else if (pd - {3'd0, rad_reg} < {{(RT-TOL_BITS){1'b0}}, tol_reg})
                            rel_reg <= REL_ON;
                        else
                        begin
                            rel_reg <= REL_OUT;
                            if (pd > {3'd0, {(C-1){1'b1}}})
                            begin
                                rad_reg <= '1;
                                sat_reg <= 1'b1;
                            end
                            else
                                rad_reg <= pd[C-2:0];
                        end
                    end
                    else
                    begin
                        d_reg <= root_reg;
                        if (s_d + s_b <= s_a)
                        begin
                            rel_reg   <= REL_INPUT_IN;
                            state_reg <= S_DONE;
                        end
                        else if (s_d + s_a <= s_b)
                        begin
                            rel_reg   <= REL_HELD_IN;
                            cx_reg    <= item_reg.in_x;
                            cy_reg    <= item_reg.in_y;
                            cz_reg    <= item_reg.in_z;
                            rad_reg   <= item_reg.in_radius;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            if (s_d >= s_ab)
                                rel_reg <= (s_d - s_ab < {{(RT+2-TOL_BITS){1'b0}}, tol_reg})
                                           ? REL_TANGENT : REL_APART;
                            else
                                rel_reg <= REL_OVERLAP;
                            newr_reg <= s_sum[RT+1:1];
                            t_reg    <= RT'(s_sum[RT+1:1] - s_a);
                            axis_reg <= '0;
                            state_reg <= S_MDIFF;
                        end
                    end
                end
                S_MDIFF:
                begin
                    neg_reg   <= diff_c[M-1];
                    mag_reg   <= diff_c[M-1] ? -diff_c : diff_c;
                    mplr_reg  <= t_reg[M-1:0];
                    num_reg   <= '0;
                    cnt_reg   <= 8'(M);
                    state_reg <= S_MMUL;
                end
                S_MMUL:
                begin
                    if (cnt_reg == 8'd0)
                    begin
                        drem_reg  <= '0;
                        q_reg     <= '0;
                        cnt_reg   <= 8'(NW);
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        if (mplr_reg[0])
                            num_reg <= num_reg + ({{(NW-M){1'b0}}, mag_reg}
                                                  << (8'(M) - cnt_reg));
                        mplr_reg <= mplr_reg >> 1;
                        cnt_reg  <= cnt_reg - 8'd1;
                    end
                end
                S_DIV:
                begin
                    if (cnt_reg == 8'd0)
                        state_reg <= S_MAPPLY;
                    else
                    begin
                        num_reg <= num_reg << 1;
                        if (d_reg != '0 && drem_sh >= {1'b0, d_reg})
                        begin
                            drem_reg <= drem_sh - {1'b0, d_reg};
                            q_reg    <= {q_reg[NW-2:0], 1'b1};
                        end
                        else
                        begin
                            drem_reg <= drem_sh;
                            q_reg    <= {q_reg[NW-2:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg - 8'd1;
                    end
                end
                S_MAPPLY:
                begin
                    case (axis_reg)
                        2'd0:    cx_reg <= (d_reg == '0) ? cx_reg : moved_c;
                        2'd1:    cy_reg <= (d_reg == '0) ? cy_reg : moved_c;
                        default: cz_reg <= (d_reg == '0) ? cz_reg : moved_c;
                    endcase
                    if (axis_reg == 2'd2)
                    begin
                        if (newr_reg > {4'd0, {(C-1){1'b1}}})
                        begin
                            rad_reg <= '1;
                            sat_reg <= 1'b1;
                        end
                        else
                            rad_reg <= newr_reg[C-2:0];
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= S_MDIFF;
                    end
                end
                S_DONE:
                begin
                    if (!ovalid_reg || !out_stall)
                    begin
                        out_reg.relation   <= rel_reg;
                        out_reg.out_x      <= cx_reg;
                        out_reg.out_y      <= cy_reg;
                        out_reg.out_z      <= cz_reg;
                        out_reg.out_radius <= rad_reg;
                        out_reg.saturated  <= sat_reg;
                        ovalid_reg         <= 1'b1;
                        state_reg          <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
